@@ hdl/u2u8_pkg.sv @@
// Shared types, constants and the unit encoder for the UCS-2 to UTF-8 encoder.
package u2u8_pkg;

  localparam logic [7:0]  BomHiByte     = 8'hFF;
  localparam logic [7:0]  BomLoByte     = 8'hFE;
  localparam logic [7:0]  Lead2Byte     = 8'hC0;
  localparam logic [7:0]  Lead3Byte     = 8'hE0;
  localparam logic [7:0]  ContByte      = 8'h80;
  localparam logic [15:0] OneByteLimit  = 16'h0080;
  localparam logic [15:0] TwoByteLimit  = 16'h0800;
  localparam int unsigned JobQDepthDef  = 4;
  localparam int unsigned MaxUnitBytes  = 3;

  // One queued job: encoded bytes of a unit plus an optional terminator.
  typedef struct packed {
    logic [MaxUnitBytes-1:0][7:0] bytes;
    logic [1:0]                   nb;
    logic                         term;
  } job_t;

  function automatic job_t encode_unit(input logic [15:0] u);
    job_t j;
    j = '0;
    if (u < OneByteLimit) begin
      j.bytes[0] = u[7:0];
      j.nb       = 2'd1;
    end else if (u < TwoByteLimit) begin
      j.bytes[0] = Lead2Byte | {3'b000, u[10:6]};
      j.bytes[1] = ContByte  | {2'b00, u[5:0]};
      j.nb       = 2'd2;
    end else begin
      j.bytes[0] = Lead3Byte | {4'b0000, u[15:12]};
      j.bytes[1] = ContByte  | {2'b00, u[11:6]};
      j.bytes[2] = ContByte  | {2'b00, u[5:0]};
      j.nb       = 2'd3;
    end
    return j;
  endfunction

endpackage

@@ hdl/u2u8_front.sv @@
// Front end: pairs input bytes, handles the byte-order mark, encodes units into jobs.
module u2u8_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      in_byte_i,
  input  logic            end_of_string_i,
  output logic            job_valid_o,
  output u2u8_pkg::job_t  job_o
);
  import u2u8_pkg::*;

  logic [7:0] held_q, held_d;
  logic       odd_q, odd_d;
  logic       le_q, le_d;
  logic       start_q, start_d;
  logic       is_data;
  logic [15:0] unit;
  job_t       enc;

  always_comb begin
    held_d  = held_q;
    odd_d   = odd_q;
    le_d    = le_q;
    start_d = start_q;
    is_data = 1'b1;
    if (!odd_q) begin
      held_d = in_byte_i;
      odd_d  = 1'b1;
    end else begin
      odd_d = 1'b0;
      if (start_q) begin
        start_d = 1'b0;
        priority if (held_q == BomHiByte && in_byte_i == BomLoByte) begin
          le_d    = 1'b1;
          is_data = 1'b0;
        end else if (held_q == BomLoByte && in_byte_i == BomHiByte) begin
          le_d    = 1'b0;
          is_data = 1'b0;
        end else begin
          le_d = 1'b0;
        end
      end
    end
    // end of string puts everything back to the reset state
    if (end_of_string_i) begin
      held_d  = '0;
      odd_d   = 1'b0;
      le_d    = 1'b0;
      start_d = 1'b1;
    end
  end

  // byte order as decided by this pair (mark check may change it)
  always_comb begin
    if (start_q ? (held_q == BomHiByte && in_byte_i == BomLoByte) : le_q) begin
      unit = {in_byte_i, held_q};
    end else begin
      unit = {held_q, in_byte_i};
    end
    enc = encode_unit(unit);
  end

  always_comb begin
    job_o      = '0;
    job_valid_o = 1'b0;
    if (odd_q && is_data) begin
      job_o.bytes = enc.bytes;
      job_o.nb    = enc.nb;
    end
    job_o.term  = end_of_string_i;
    job_valid_o = (odd_q && is_data) || end_of_string_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= '0;
      odd_q   <= 1'b0;
      le_q    <= 1'b0;
      start_q <= 1'b1;
    end else if (accept_i) begin
      held_q  <= held_d;
      odd_q   <= odd_d;
      le_q    <= le_d;
      start_q <= start_d;
    end
  end

endmodule

@@ hdl/u2u8_job_fifo.sv @@
// Small job queue between front end and serializer.
module u2u8_job_fifo #(
  parameter int unsigned Depth = u2u8_pkg::JobQDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  u2u8_pkg::job_t  wr_data_i,
  input  logic            rd_i,
  output u2u8_pkg::job_t  rd_data_o,
  output logic            full_o,
  output logic            empty_o
);
  import u2u8_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  job_t          mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == LastPtr) ? '0 : wp_q + AW'(1);
      end
      if (do_rd) begin
        rp_q <= (rp_q == LastPtr) ? '0 : rp_q + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

@@ hdl/u2u8_back.sv @@
// Back end: one job word per cycle into the output register, when not stalled.
module u2u8_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_empty_i,
  input  u2u8_pkg::job_t  job_i,
  output logic            job_pop_o,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o,
  output logic            empty_o,
  input  logic            pop_i
);
  import u2u8_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       emit, is_term, final_word;
  logic [2:0] total;

  assign total      = {1'b0, job_i.nb} + {2'b00, job_i.term};
  assign emit       = !job_empty_i && (!valid_q || pop_i);
  assign is_term    = (idx_q >= job_i.nb);
  assign final_word = ({1'b0, idx_q} + 3'd1 == total);
  assign job_pop_o  = emit && final_word;

  always_comb begin
    idx_d   = idx_q;
    byte_d  = byte_q;
    last_d  = last_q;
    valid_d = valid_q;
    if (pop_i && valid_q) begin
      valid_d = 1'b0;
    end
    if (emit) begin
      valid_d = 1'b1;
      byte_d  = is_term ? 8'h00 : job_i.bytes[idx_q];
      last_d  = is_term;
      idx_d   = final_word ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_byte_o = byte_q;
  assign out_last_o = last_q;
  assign empty_o    = !valid_q;

endmodule

@@ hdl/ucs2_to_utf8_encoder.sv @@
// Top level of the UCS-2 to UTF-8 stream encoder.
// Push one UCS-2 byte per cycle, with end_of_string_i on the final byte of a string.
// A leading FF FE or FE FF byte-order mark is dropped and sets the order (big-endian
// if absent); each 16-bit unit comes out as 1 to 3 UTF-8 words, and every string
// closes with a zero word flagged by out_last_o. A trailing odd byte is dropped and
// surrogates are encoded as plain three-byte units. Input takes one byte per cycle
// while the job queue (JobQDepth entries) has room; the output serializer produces
// one word per cycle while words are popped, with up to three output words per two
// input bytes plus the closing zero word. The first output word of a unit is written
// into the job queue and then the output register before reaching the output ports.
module ucs2_to_utf8_encoder #(
  parameter int unsigned JobQDepth = u2u8_pkg::JobQDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import u2u8_pkg::*;

  logic accept;
  logic job_valid, q_full, q_empty, q_pop;
  job_t job_in, job_head;

  assign full   = q_full;
  assign accept = push && !q_full;

  u2u8_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .job_valid_o     (job_valid),
    .job_o           (job_in)
  );

  u2u8_job_fifo #(
    .Depth (JobQDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept && job_valid),
    .wr_data_i (job_in),
    .rd_i      (q_pop),
    .rd_data_o (job_head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  u2u8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (q_empty),
    .job_i       (job_head),
    .job_pop_o   (q_pop),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

@@ verif/ucs2_to_utf8_encoder_test.sv @@
// Self-checking testbench for the UCS-2 to UTF-8 stream encoder: directed and random strings.
module ucs2_to_utf8_encoder_test;
  import u2u8_pkg::*;

  localparam int unsigned RandomBytes    = 140;
  localparam int unsigned MaxGap         = 8;
  localparam int unsigned HoldCycles     = 150;
  localparam int unsigned HoldAfterBytes = 40;
  localparam int unsigned DrainCycles    = 20;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned ReportLimit    = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } ucs2_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_word_t;

  typedef enum int { StrNoise, StrLittle, StrBig, StrNoMark } str_kind_e;
  typedef enum int { UnitAscii, UnitTwoByte, UnitThreeByte, UnitSurrogate, UnitAny } unit_kind_e;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       push          = 1'b0;
  logic       full;
  logic [7:0] in_byte       = 8'h00;
  logic       end_of_string = 1'b0;
  logic       empty;
  logic       pop           = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  ucs2_to_utf8_encoder u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .in_byte_i      (in_byte),
    .end_of_string_i(end_of_string),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .out_last_o     (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  ucs2_byte_t  ucs2_pending[$];
  utf8_word_t  utf8_due[$];
  int unsigned mismatches   = 0;
  int unsigned bytes_taken  = 0;
  int unsigned cycle_count  = 0;
  logic        hold_on      = 1'b0;

  // Encoder state mirror
  logic [7:0] pair_first   = 8'h00;
  logic       pair_open    = 1'b0;
  logic       order_le     = 1'b0;
  logic       mark_pending = 1'b1;

  function automatic void queue_word(input logic [7:0] data, input logic last);
    utf8_word_t w;
    w.data = data;
    w.last = last;
    utf8_due.push_back(w);
  endfunction

  function automatic void encode_ucs2_byte(input logic [7:0] b, input logic eos);
    logic [15:0] unit;
    logic        is_data;
    if (!pair_open) begin
      pair_first = b;
      pair_open  = 1'b1;
    end else begin
      pair_open = 1'b0;
      is_data   = 1'b1;
      // only the first pair of a string can be a byte-order mark
      if (mark_pending) begin
        mark_pending = 1'b0;
        order_le     = 1'b0;
        if (pair_first == BomHiByte && b == BomLoByte) begin
          order_le = 1'b1;
          is_data  = 1'b0;
        end else if (pair_first == BomLoByte && b == BomHiByte) begin
          is_data = 1'b0;
        end
      end
      if (is_data) begin
        unit = order_le ? {b, pair_first} : {pair_first, b};
        if (unit < OneByteLimit) begin
          queue_word(unit[7:0], 1'b0);
        end else if (unit < TwoByteLimit) begin
          queue_word({3'b110, unit[10:6]}, 1'b0);
          queue_word({2'b10, unit[5:0]}, 1'b0);
        end else begin
          queue_word({4'b1110, unit[15:12]}, 1'b0);
          queue_word({2'b10, unit[11:6]}, 1'b0);
          queue_word({2'b10, unit[5:0]}, 1'b0);
        end
      end
    end
    // terminator closes the string; a held odd byte is dropped
    if (eos) begin
      queue_word(8'h00, 1'b1);
      pair_first   = 8'h00;
      pair_open    = 1'b0;
      order_le     = 1'b0;
      mark_pending = 1'b1;
    end
  endfunction

  task automatic add_byte(input logic [7:0] data, input logic eos);
    ucs2_byte_t item;
    item.data = data;
    item.eos  = eos;
    ucs2_pending.push_back(item);
  endtask

  task automatic add_unit(input logic [15:0] unit, input logic le, input logic eos);
    if (le) begin
      add_byte(unit[7:0], 1'b0);
      add_byte(unit[15:8], eos);
    end else begin
      add_byte(unit[15:8], 1'b0);
      add_byte(unit[7:0], eos);
    end
  endtask

  function automatic logic [15:0] draw_unit();
    unit_kind_e kind;
    kind = unit_kind_e'($urandom_range(UnitAscii, UnitAny));
    case (kind)
      UnitAscii:     return 16'($urandom_range(16'h0000, 16'h007F));
      UnitTwoByte:   return 16'($urandom_range(16'h0080, 16'h07FF));
      UnitThreeByte: return 16'($urandom_range(16'h0800, 16'hFFFF));
      UnitSurrogate: return 16'($urandom_range(16'hD800, 16'hDFFF));
      default:       return 16'($urandom_range(16'h0000, 16'hFFFF));
    endcase
  endfunction

  task automatic add_random_string();
    str_kind_e   kind;
    int unsigned n_units;
    int unsigned n_bytes;
    logic        le;
    logic        odd;
    case ($urandom_range(0, 9))
      0:       kind = StrNoise;
      1, 2, 3: kind = StrLittle;
      4, 5, 6: kind = StrBig;
      default: kind = StrNoMark;
    endcase
    if (kind == StrNoise) begin
      // broken strings: often start like a mark, then random bytes
      n_bytes = $urandom_range(1, 6);
      for (int i = 0; i < n_bytes; i++) begin
        if (i < 2 && $urandom_range(0, 1) == 0)
          add_byte($urandom_range(0, 1) ? BomHiByte : BomLoByte, i == n_bytes - 1);
        else
          add_byte(8'($urandom_range(0, 255)), i == n_bytes - 1);
      end
    end else begin
      le      = (kind == StrLittle);
      n_units = $urandom_range(0, 6);
      odd     = ($urandom_range(0, 3) == 0);
      if (kind != StrNoMark)
        add_unit(16'hFEFF, le, n_units == 0 && !odd);
      for (int i = 0; i < n_units; i++)
        add_unit(draw_unit(), le, i == n_units - 1 && !odd);
      if (odd || (kind == StrNoMark && n_units == 0))
        add_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // Sender
  int unsigned push_gap   = 0;
  logic        push_burst = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        encode_ucs2_byte(in_byte, end_of_string);
        void'(ucs2_pending.pop_front());
        bytes_taken++;
        if ($urandom_range(0, 31) == 0) push_burst = !push_burst;
        push_gap = push_burst ? 0 : $urandom_range(0, MaxGap);
      end
      if (!push || !full) begin
        if (push_gap != 0) begin
          push_gap--;
          push <= 1'b0;
        end else if (ucs2_pending.size() != 0) begin
          push          <= 1'b1;
          in_byte       <= ucs2_pending[0].data;
          end_of_string <= ucs2_pending[0].eos;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver
  int unsigned pop_gap   = 0;
  logic        pop_burst = 1'b0;

  always @(posedge clk_i) begin
    utf8_word_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (utf8_due.size() == 0) begin
          if (mismatches < ReportLimit)
            $display("unexpected word: byte %h last %b", out_byte_o, out_last_o);
          mismatches++;
        end else begin
          want = utf8_due.pop_front();
          if (out_byte_o !== want.data || out_last_o !== want.last) begin
            if (mismatches < ReportLimit)
              $display("word mismatch: expected byte %h last %b, got byte %h last %b",
                       want.data, want.last, out_byte_o, out_last_o);
            mismatches++;
          end
        end
        if ($urandom_range(0, 31) == 0) pop_burst = !pop_burst;
        pop_gap = pop_burst ? 0 : $urandom_range(0, MaxGap);
      end
      if (hold_on) begin
        pop <= 1'b0;
      end else if (pop_gap != 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // One long receiver stall so the job queue fills and backs up the input
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
    end else if (!hold_done && bytes_taken >= HoldAfterBytes) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    hold_on <= (hold_left != 0);
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int unsigned n_directed;
    // one-byte string
    add_byte(8'hAB, 1'b1);
    // little-endian mark, class boundaries, trailing odd byte
    add_unit(16'hFEFF, 1'b1, 1'b0);
    add_unit(16'h007F, 1'b1, 1'b0);
    add_unit(16'h0080, 1'b1, 1'b0);
    add_unit(16'h07FF, 1'b1, 1'b0);
    add_byte(8'h55, 1'b1);
    // big-endian mark, three-byte units, lone surrogates
    add_unit(16'hFEFF, 1'b0, 1'b0);
    add_unit(16'h0800, 1'b0, 1'b0);
    add_unit(16'hFFFF, 1'b0, 1'b0);
    add_unit(16'hD800, 1'b0, 1'b0);
    add_unit(16'hDFFF, 1'b0, 1'b1);
    // no mark; mark-like units further in are plain data
    add_unit(16'h0000, 1'b0, 1'b0);
    add_unit(16'hFFFE, 1'b0, 1'b0);
    add_unit(16'hFEFF, 1'b0, 1'b1);
    n_directed = ucs2_pending.size();
    while (ucs2_pending.size() < n_directed + RandomBytes) add_random_string();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ucs2_pending.size() != 0) @(posedge clk_i);
    while (utf8_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ ucs2_to_utf8_encoder.f @@
hdl/u2u8_pkg.sv
hdl/u2u8_front.sv
hdl/u2u8_job_fifo.sv
hdl/u2u8_back.sv
hdl/ucs2_to_utf8_encoder.sv
verif/ucs2_to_utf8_encoder_test.sv
